FILE: src/double_ended_queue_defines.svh
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that a condition never holds outside reset.
`define DQ_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("deque check failed: never");

// Check that the consequent holds in the same cycle as the antecedent.
`define DQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same cycle");

// Check that the consequent holds in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next cycle");

`endif

FILE: src/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DQ_DEPTH      = 64;
    localparam int DQ_DATA_WIDTH = 32;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: src/dq_mem.sv
`timescale 1ns / 1ps

module dq_mem
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic signed [VALUE_W-1:0]   i_value,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [STATUS_W-1:0]         o_status,
    output logic signed [VALUE_W-1:0]   o_value_res,
    output logic                        o_last,
    // memory port
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [DATA_WIDTH-1:0]       o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [DATA_WIDTH-1:0]       i_rdata
);

    localparam int WW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_front, n_front;
    logic [CW-1:0]             r_count, n_count;
    logic [AW-1:0]             r_idx,   n_idx;
    logic                      r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]       r_out_status, n_out_status;
    logic signed [VALUE_W-1:0] r_out_value,  n_out_value;
    logic                      r_out_last,   n_out_last;

    logic                      out_free;
    logic                      accept;
    logic                      is_empty;
    logic                      is_full;
    logic                      dump_last;
    logic signed [WW-1:0]      in_ext;
    logic signed [WW-1:0]      rd_ext;
    logic signed [VALUE_W-1:0] rd_value;

    // Ring slot at offset from a base, both below DEPTH.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] offs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = !((r_state == S_IDLE) && out_free);
    assign accept    = i_valid && !o_stall;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count == CW'(DEPTH));
    assign dump_last = (CW'(r_idx) == (r_count - CW'(1)));

    // Keep the low DATA_WIDTH bits on the way in, sign-extend on the way out.
    assign in_ext   = WW'(i_value);
    assign o_wdata  = in_ext[DATA_WIDTH-1:0];
    assign rd_ext   = WW'(signed'(i_rdata));
    assign rd_value = rd_ext[VALUE_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        o_we         = 1'b0;
        o_waddr      = r_front;
        o_re         = 1'b0;
        o_raddr      = r_front;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_last  = 1'b1;
                            if (is_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                o_we         = 1'b1;
                                n_count      = r_count + CW'(1);
                                if (i_func == FN_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ? AW'(DEPTH - 1)
                                                              : r_front - AW'(1);
                                    o_waddr = n_front;
                                end else begin
                                    o_waddr = wrap_add(r_front, AW'(r_count));
                                end
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK: begin
                            if (is_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_value  = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                n_count = r_count - CW'(1);
                                n_state = S_RD;
                                if (i_func == FN_POP_FRONT) begin
                                    o_raddr = r_front;
                                    n_front = wrap_add(r_front, AW'(1));
                                end else begin
                                    o_raddr = wrap_add(r_front, AW'(r_count - CW'(1)));
                                end
                            end
                        end
                        FN_DUMP: begin
                            if (is_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_value  = '0;
                                n_out_last   = 1'b1;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_front;
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes: drop the item
                        end
                    endcase
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = rd_value;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                // Emit one entry per free output slot; prefetch the next one.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_value  = rd_value;
                    n_out_last   = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        o_re    = 1'b1;
                        o_raddr = wrap_add(r_front, n_idx);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_res = r_out_value;
    assign o_last      = r_out_last;

endmodule

FILE: src/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_func, i_value
// output   out        o_valid / i_stall   o_status, o_value_res, o_last
//
// A push registers its result directly; a pop reads the memory first (state S_RD), then registers the result.
// A dump reads every entry from the front, one result per cycle while the output is not stalled.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
// A stalled result holds in the output register; the input stalls while it cannot move and during a pop or dump.
`include "double_ended_queue_defines.svh"

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [VALUE_W-1:0] o_value_res,
    output logic                      o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value_res (o_value_res),
        .o_last      (o_last),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    dq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `DQ_ASSERT_NEVER(a_no_rw_same_cycle, w_we && w_re)
    `DQ_ASSERT_IMPL(a_no_accept_when_blocked, i_valid && !o_stall, !(o_valid && i_stall))
    `DQ_ASSERT_NEXT(a_no_write_after_read, w_re, !w_we)

endmodule
